/* rtl/lzwd_pkg.sv */
// Package for the LZW code decoder: shared types, status codes and constants.
// Used by the engine, the string buffer and the top level. No dependencies.
`default_nettype none
package lzwd_pkg;

  localparam int MAX_CODE_BITS_LIMIT = 16;
  localparam int MinWidth = 9;
  localparam int AddrW = MAX_CODE_BITS_LIMIT;
  localparam int LenW = MAX_CODE_BITS_LIMIT + 1;
  localparam logic [LenW-1:0] CLEAR_CODE = LenW'(256);

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOBYTE  = 2'd2;
  localparam logic [1:0] ST_PENDING = 2'd3;

  // Item operations.
  localparam logic OP_CODE = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // Configuration register indexes.
  localparam logic REG_MAX_BITS = 1'b0;
  localparam logic REG_BLOCK    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_WALK = 4'b0100,
    S_PULL = 4'b1000
  } state_t;

  // One dictionary entry: its parent code, appended byte, first byte and length.
  typedef struct packed {
    logic [AddrW-1:0] parent;
    logic [7:0]       chr;
    logic [7:0]       head;
    logic [LenW-1:0]  len;
  } dict_entry_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [LenW-1:0] string_length;
    logic [7:0]      out_byte;
    logic            last;
    logic            cleared;
    logic [4:0]      code_width;
  } res_t;

  typedef struct packed {
    logic            clr;
    logic            clr_block;
    logic            blk_mode;
    logic [LenW-1:0] maxsym;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic [AddrW-1:0] raddr;
  } buf_req_t;

endpackage
`default_nettype wire

/* rtl/lzwd_in_if.sv */
// Input channel of the LZW code decoder: valid/ready with op and code.
// No dependencies.
`default_nettype none
interface lzwd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] code;
  modport source (output valid, output op, output code, input ready);
  modport sink (input valid, input op, input code, output ready);
endinterface
`default_nettype wire

/* rtl/lzwd_out_if.sv */
// Result channel of the LZW code decoder: valid/ready with the result fields.
// No dependencies.
`default_nettype none
interface lzwd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [16:0] string_length;
  logic [7:0]  out_byte;
  logic        last;
  logic        cleared;
  logic [4:0]  code_width;
  modport source (output valid, output status, output string_length, output out_byte,
                  output last, output cleared, output code_width, input ready);
  modport sink (input valid, input status, input string_length, input out_byte,
                input last, input cleared, input code_width, output ready);
endinterface
`default_nettype wire

/* rtl/lzwd_strbuf.sv */
// Expanded-string buffer: one write port and one registered read port.
// Depends on lzwd_pkg.
`default_nettype none
module lzwd_strbuf (
  input  wire logic              clk,
  input  wire lzwd_pkg::buf_req_t req,
  output      logic [7:0]        rdata
);
  import lzwd_pkg::*;

  logic [7:0] mem [0:(1<<AddrW)-1];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

/* rtl/lzwd_engine.sv */
// Decoder engine: dictionary memory, code checks, entry insertion and tree walk.
// Depends on lzwd_pkg; drives the string buffer through a request struct.
`default_nettype none
module lzwd_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                op,
  input  wire logic [15:0]         code,
  input  wire lzwd_pkg::cfg_t      cfg,
  output      logic                idle,
  output      logic                res_valid,
  output      lzwd_pkg::res_t      res,
  output      lzwd_pkg::buf_req_t  breq,
  input  wire logic [7:0]          brdata
);
  import lzwd_pkg::*;

  state_t state_r, state_nxt;
  logic [LenW-1:0]  nfc_r, nfc_nxt;
  logic [AddrW-1:0] prev_r, prev_nxt;
  logic             pv_r, pv_nxt;
  logic [4:0]       width_r, width_nxt;
  logic [LenW-1:0]  pend_r, pend_nxt;
  logic [AddrW-1:0] rp_r, rp_nxt;
  logic [LenW-1:0]  prev_len_r, prev_len_nxt;
  logic [7:0]       prev_head_r, prev_head_nxt;
  logic [AddrW-1:0] code_r, code_nxt;
  logic             kw_r, kw_nxt;
  logic             add_r, add_nxt;
  logic [AddrW-1:0] t_r, t_nxt;
  logic [AddrW-1:0] pos_r, pos_nxt;
  logic [LenW-1:0]  len_r, len_nxt;

  // Dictionary memory with write-to-read forwarding.
  dict_entry_t      dict [0:(1<<AddrW)-1];
  dict_entry_t      rd_q, rd_data, fwd_d_r, wd;
  logic             fwd_r;
  logic             we;
  logic [AddrW-1:0] wa, rd_addr;

  logic [LenW-1:0] code_ext, nfc_inc, look_len;
  logic [7:0]      look_fb;
  logic            bad_code;

  always_ff @(posedge clk) begin
    if (we) begin
      dict[wa] <= wd;
    end
    rd_q    <= dict[rd_addr];
    fwd_r   <= we && (wa == rd_addr);
    fwd_d_r <= wd;
  end

  assign rd_data = fwd_r ? fwd_d_r : rd_q;

  assign code_ext = LenW'(code);
  assign nfc_inc  = nfc_r + LenW'(1);
  assign bad_code = (code_ext > nfc_r) || (!pv_r && code_ext >= CLEAR_CODE) ||
                    (code_ext == nfc_r && nfc_r >= cfg.maxsym);

  // First byte and length of the current code once its entry is read.
  always_comb begin
    if (kw_r) begin
      look_fb  = prev_head_r;
      look_len = prev_len_r + LenW'(1);
    end else if (code_r[AddrW-1:8] == '0) begin
      look_fb  = code_r[7:0];
      look_len = LenW'(1);
    end else begin
      look_fb  = rd_data.head;
      look_len = rd_data.len;
    end
  end

  // Control and state update.
  always_comb begin
    state_nxt     = state_r;
    nfc_nxt       = nfc_r;
    prev_nxt      = prev_r;
    pv_nxt        = pv_r;
    width_nxt     = width_r;
    pend_nxt      = pend_r;
    rp_nxt        = rp_r;
    prev_len_nxt  = prev_len_r;
    prev_head_nxt = prev_head_r;
    code_nxt      = code_r;
    kw_nxt        = kw_r;
    add_nxt       = add_r;
    t_nxt         = t_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    we            = 1'b0;
    wa            = nfc_r[AddrW-1:0];
    wd            = '{parent: prev_r, chr: look_fb, head: prev_head_r,
                      len: prev_len_r + LenW'(1)};
    rd_addr       = code;
    breq          = '{we: 1'b0, waddr: pos_r, wdata: rd_data.chr, raddr: rp_r};
    res_valid     = 1'b0;
    res           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (op == OP_PULL) begin
            if (pend_r == '0) begin
              res_valid  = 1'b1;
              res.status = ST_NOBYTE;
            end else begin
              state_nxt = S_PULL;
            end
          end else if (pend_r != '0) begin
            res_valid  = 1'b1;
            res.status = ST_PENDING;
          end else if (cfg.blk_mode && code_ext == CLEAR_CODE) begin
            nfc_nxt     = CLEAR_CODE + LenW'(cfg.blk_mode);
            pv_nxt      = 1'b0;
            prev_nxt    = '0;
            width_nxt   = 5'(MinWidth);
            res_valid   = 1'b1;
            res.cleared = 1'b1;
          end else if (bad_code) begin
            res_valid  = 1'b1;
            res.status = ST_INVALID;
          end else begin
            code_nxt  = code;
            kw_nxt    = (code_ext == nfc_r);
            add_nxt   = pv_r && (nfc_r < cfg.maxsym);
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        // Insert the new entry, then restart the read at the code itself.
        if (add_r) begin
          we      = 1'b1;
          nfc_nxt = nfc_inc;
          if (nfc_inc != cfg.maxsym && (nfc_inc & (nfc_inc - LenW'(1))) == '0) begin
            width_nxt = width_r + 5'd1;
          end
        end
        prev_nxt      = code_r;
        pv_nxt        = 1'b1;
        prev_len_nxt  = look_len;
        prev_head_nxt = look_fb;
        pend_nxt      = look_len;
        rp_nxt        = '0;
        len_nxt       = look_len;
        pos_nxt       = AddrW'(look_len - LenW'(1));
        t_nxt         = code_r;
        rd_addr       = code_r;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        // One string byte a cycle, written from the end toward the front.
        breq.we = 1'b1;
        if (t_r[AddrW-1:8] != '0) begin
          t_nxt   = rd_data.parent;
          pos_nxt = pos_r - AddrW'(1);
          rd_addr = rd_data.parent;
        end else begin
          breq.waddr        = '0;
          breq.wdata        = t_r[7:0];
          res_valid         = 1'b1;
          res.string_length = len_r;
          state_nxt         = S_IDLE;
        end
      end
      S_PULL: begin
        pend_nxt     = pend_r - LenW'(1);
        rp_nxt       = rp_r + AddrW'(1);
        res_valid    = 1'b1;
        res.out_byte = brdata;
        res.last     = (pend_r == LenW'(1));
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write empties the table and drops pending bytes.
    if (cfg.clr) begin
      nfc_nxt   = CLEAR_CODE + LenW'(cfg.clr_block);
      pv_nxt    = 1'b0;
      prev_nxt  = '0;
      width_nxt = 5'(MinWidth);
      pend_nxt  = '0;
      rp_nxt    = '0;
    end
    res.code_width = width_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nfc_r   <= CLEAR_CODE + LenW'(1);
      prev_r  <= '0;
      pv_r    <= 1'b0;
      width_r <= 5'(MinWidth);
      pend_r  <= '0;
      rp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      nfc_r   <= nfc_nxt;
      prev_r  <= prev_nxt;
      pv_r    <= pv_nxt;
      width_r <= width_nxt;
      pend_r  <= pend_nxt;
      rp_r    <= rp_nxt;
    end
  end

  // Working registers of the walk.
  always_ff @(posedge clk) begin
    prev_len_r  <= prev_len_nxt;
    prev_head_r <= prev_head_nxt;
    code_r      <= code_nxt;
    kw_r        <= kw_nxt;
    add_r       <= add_nxt;
    t_r         <= t_nxt;
    pos_r       <= pos_nxt;
    len_r       <= len_nxt;
  end

  assign idle = (state_r == S_IDLE);

  // Checks on the engine's own bookkeeping.
  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    (width_r >= 5'(MinWidth)) && (width_r <= 5'(MAX_CODE_BITS_LIMIT)))
    else $error("code width out of range");
  a_nfc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r <= cfg.maxsym || cfg.clr)
    else $error("next free code beyond table size");
  a_last_pull: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PULL && pend_r == LenW'(1)) |=> (pend_r == '0))
    else $error("pending count not drained by final pull");
  a_busy_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !start)
    else $error("item taken while engine busy");

endmodule
`default_nettype wire

/* rtl/lzw_compress_code_decoder.sv */
// LZW code decoder top level (Unix compress style, block mode).
// An accepted code is expanded by the tree walk, which reads one dictionary entry
// per cycle through a single memory read port.
// One item is in work at a time. Reset is synchronous and clears control state;
// the dictionary and string buffer are never cleared and need no clearing pass.
`default_nettype none
module lzw_compress_code_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lzwd_in_if.sink          in_ch,
  lzwd_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);
  import lzwd_pkg::*;

  logic [4:0] max_bits_r;
  logic       block_r;
  logic       cfg_wr;
  logic [4:0] bits_eff;
  cfg_t       cfg;
  logic       idle, res_valid, start;
  res_t       res, out_r;
  logic       out_valid_r;
  buf_req_t   breq;
  logic [7:0] brdata;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bits_r <= 5'(MAX_CODE_BITS_LIMIT);
      block_r    <= 1'b1;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MAX_BITS) begin
        max_bits_r <= cfg_pwdata[4:0];
      end else begin
        block_r <= cfg_pwdata[0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_BITS) ? {27'd0, max_bits_r} : {31'd0, block_r};

  // Table size from the clamped width.
  always_comb begin
    priority if (max_bits_r < 5'(MinWidth)) begin
      bits_eff = 5'(MinWidth);
    end else if (max_bits_r > 5'(MAX_CODE_BITS_LIMIT)) begin
      bits_eff = 5'(MAX_CODE_BITS_LIMIT);
    end else begin
      bits_eff = max_bits_r;
    end
  end

  assign cfg.clr        = cfg_wr;
  assign cfg.clr_block  = (cfg_paddr[2] == REG_BLOCK) ? cfg_pwdata[0] : block_r;
  assign cfg.blk_mode   = block_r;
  assign cfg.maxsym     = LenW'(1) << bits_eff;

  // Input transfer when the engine is idle and the result slot frees up.
  assign in_ch.ready = idle && (!out_valid_r || out_ch.ready);
  assign start       = in_ch.valid && in_ch.ready;

  lzwd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_ch.op),
    .code      (in_ch.code),
    .cfg       (cfg),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .breq      (breq),
    .brdata    (brdata)
  );

  lzwd_strbuf u_strbuf (
    .clk   (clk),
    .req   (breq),
    .rdata (brdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.string_length = out_r.string_length;
  assign out_ch.out_byte      = out_r.out_byte;
  assign out_ch.last          = out_r.last;
  assign out_ch.cleared       = out_r.cleared;
  assign out_ch.code_width    = out_r.code_width;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the LZW code decoder: drives codes and byte pulls,
// predicts each result and writes the configuration over the APB-style port.
// Depends on lzwd_pkg, lzwd_in_if, lzwd_out_if and lzw_compress_code_decoder.
`timescale 1ns / 1ps
module tb_top;
  import lzwd_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lzwd_in_if  in_ch ();
  lzwd_out_if out_ch ();

  lzw_compress_code_decoder dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Decoder state as the testbench tracks it.
  logic [15:0] dict_parent [65536];
  logic [7:0]  dict_chr [65536];
  logic [7:0]  str_buf [65536];
  int unsigned next_code, prev_code, cur_width, bytes_left, rd_ptr;
  bit          prev_ok;
  logic [4:0]  max_bits;
  logic        blk;

  res_t        expected_results [$];
  int          errors = 0;
  bit          no_idle = 1'b0;
  int          idle_cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int unsigned table_limit();
    int unsigned bits;
    bits = max_bits;
    if (bits < MinWidth) bits = MinWidth;
    if (bits > MAX_CODE_BITS_LIMIT) bits = MAX_CODE_BITS_LIMIT;
    return 1 << bits;
  endfunction

  function automatic void reset_table();
    next_code = 256 + blk;
    prev_code = 0;
    prev_ok = 1'b0;
    cur_width = MinWidth;
  endfunction

  function automatic logic [7:0] head_byte(input int unsigned c);
    while (c >= 256) c = dict_parent[c];
    return c[7:0];
  endfunction

  // Expand a code into the string buffer and return its length.
  function automatic int unsigned expand_string(input int unsigned c);
    int unsigned len, t, pos;
    len = 1;
    t = c;
    while (t >= 256) begin
      t = dict_parent[t];
      len++;
    end
    pos = len;
    t = c;
    while (pos > 1 && t >= 256) begin
      pos--;
      str_buf[pos] = dict_chr[t];
      t = dict_parent[t];
    end
    str_buf[0] = t[7:0];
    return len;
  endfunction

  function automatic res_t decode_item(input logic op, input logic [15:0] code);
    res_t r;
    int unsigned limit;
    r = '0;
    limit = table_limit();
    if (op == OP_PULL) begin
      if (bytes_left == 0) begin
        r.status = ST_NOBYTE;
      end else begin
        r.out_byte = str_buf[rd_ptr];
        rd_ptr = (rd_ptr + 1) & 16'hFFFF;
        bytes_left--;
        r.last = (bytes_left == 0);
      end
    end else if (bytes_left != 0) begin
      r.status = ST_PENDING;
    end else if (blk && code == CLEAR_CODE[15:0]) begin
      reset_table();
      r.cleared = 1'b1;
    end else if (code > next_code || (!prev_ok && code >= 256) ||
                 (code == next_code && next_code >= limit)) begin
      r.status = ST_INVALID;
    end else begin
      if (prev_ok && next_code < limit) begin
        dict_chr[next_code] = head_byte(code == next_code ? prev_code : code);
        dict_parent[next_code] = prev_code[15:0];
        next_code++;
        if (next_code != limit && (next_code & (next_code - 1)) == 0) cur_width++;
      end
      prev_code = code;
      prev_ok = 1'b1;
      bytes_left = expand_string(code);
      r.string_length = bytes_left[LenW-1:0];
      rd_ptr = 0;
    end
    r.code_width = cur_width[4:0];
    return r;
  endfunction

  // Send one item; the expectation is formed at the transfer.
  task automatic send_item(input logic op, input logic [15:0] code);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.code = code;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(decode_item(op, code));
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register while idle, then read it back.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_MAX_BITS) ? 32'h1F : 32'h1;
    drain();
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if ((cfg_prdata & mask) != (value & mask)) report("register read", cfg_prdata & mask,
                                                      value & mask);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (idx == REG_MAX_BITS) max_bits = value[4:0];
    else blk = value[0];
    bytes_left = 0;
    rd_ptr = 0;
    reset_table();
  endtask

  task automatic pull_all();
    while (bytes_left != 0) send_item(OP_PULL, '0);
  endtask

  // Submit a well-formed code: a literal first, then any code up to the next free one.
  task automatic send_good_code();
    int unsigned c;
    if (!prev_ok || $urandom_range(3) == 0) c = $urandom_range(255);
    else if ($urandom_range(4) == 0) c = next_code;
    else c = $urandom_range(next_code > 0 ? next_code - 1 : 0, 256 + blk);
    if (c >= table_limit()) c = $urandom_range(255);
    if (blk && c == CLEAR_CODE) c = 0;
    send_item(OP_CODE, c[15:0]);
  endtask

  // Extremes, every status, clear, KwKwK and first-code cases.
  task automatic test_directed();
    send_item(OP_PULL, '0);
    send_item(OP_CODE, 16'd300);
    send_item(OP_CODE, 16'd0);
    send_item(OP_CODE, 16'd65);
    pull_all();
    send_item(OP_CODE, 16'd255);
    send_item(OP_CODE, 16'hFFFF);
    pull_all();
    send_item(OP_CODE, 16'd65);
    send_item(OP_PULL, '0);
    send_item(OP_CODE, 16'd66);
    pull_all();
    send_item(OP_CODE, next_code[15:0]);
    pull_all();
    send_item(OP_CODE, next_code[15:0]);
    pull_all();
    send_item(OP_CODE, 16'(next_code + 1));
    send_item(OP_CODE, CLEAR_CODE[15:0]);
    send_item(OP_CODE, 16'd258);
    send_item(OP_CODE, 16'd7);
    pull_all();
    send_item(OP_PULL, '0);
  endtask

  // Non-block mode: code 256 is an ordinary code, never a clear.
  task automatic test_plain_mode();
    write_reg(REG_BLOCK, 32'hFFFF_FFFE);
    send_item(OP_CODE, CLEAR_CODE[15:0]);
    send_item(OP_CODE, 16'd1);
    pull_all();
    send_item(OP_CODE, CLEAR_CODE[15:0]);
    pull_all();
    send_item(OP_CODE, CLEAR_CODE[15:0]);
    pull_all();
  endtask

  // Fill a nine-bit table: the width never grows, then a full table refuses the next code.
  task automatic test_full_table();
    write_reg(REG_MAX_BITS, 32'hA5A5_A5E9);
    write_reg(REG_BLOCK, 32'h0);
    no_idle = 1'b1;
    while (next_code < table_limit()) begin
      send_item(OP_CODE, 16'($urandom_range(255)));
      pull_all();
    end
    no_idle = 1'b0;
    send_item(OP_CODE, next_code[15:0]);
    send_item(OP_CODE, 16'(next_code - 1));
    pull_all();
    send_item(OP_CODE, 16'd200);
    pull_all();
  endtask

  // Mostly well-formed code and pull sequences, with noise and broken sequences.
  task automatic test_random(input int n_items);
    int cnt;
    int unsigned pick;
    for (cnt = 0; cnt < n_items; cnt++) begin
      if (cnt == n_items / 3) no_idle = 1'b1;
      if (cnt == n_items / 2) begin
        no_idle = 1'b0;
        // Hold off until every result is in.
        drain();
      end
      pick = $urandom_range(99);
      if (pick < 8) send_item(1'($urandom_range(1)), 16'($urandom));
      else if (pick < 11 && blk) send_item(OP_CODE, CLEAR_CODE[15:0]);
      else if (bytes_left != 0 && pick < 95) send_item(OP_PULL, 16'($urandom));
      else send_good_code();
    end
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
        if (out_ch.string_length !== want.string_length)
          report("string_length", out_ch.string_length, want.string_length);
        if (out_ch.out_byte !== want.out_byte) report("out_byte", out_ch.out_byte, want.out_byte);
        if (out_ch.last !== want.last) report("last", out_ch.last, want.last);
        if (out_ch.cleared !== want.cleared) report("cleared", out_ch.cleared, want.cleared);
        if (out_ch.code_width !== want.code_width)
          report("code_width", out_ch.code_width, want.code_width);
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk) out_ch.ready <= no_idle || ($urandom_range(99) >= 29);

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_CODE;
    in_ch.code = '0;
    out_ch.ready = 1'b0;
    max_bits = 5'd16;
    blk = 1'b1;
    bytes_left = 0;
    rd_ptr = 0;
    reset_table();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_plain_mode();
    test_full_table();
    write_reg(REG_MAX_BITS, 32'h0);
    write_reg(REG_BLOCK, 32'h1);
    test_random(50);
    write_reg(REG_MAX_BITS, 32'h1F);
    test_random(60);
    write_reg(REG_MAX_BITS, 32'hFFFF_FFF0);
    test_random(50);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
